>>> sv/ckah_pkg.sv
// Package for the color key alpha and hold block.
// Holds the pixel carrier type, register indexes and fixed-point constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ckah_pkg;

  typedef struct packed {
    logic [15:0] r_raw;
    logic [15:0] g_raw;
    logic [15:0] b_raw;
    logic [15:0] a_raw;
    logic [15:0] r_sat;
    logic [15:0] g_sat;
    logic [15:0] b_sat;
  } pix_t;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_DEPTH     = 3'd1;
  localparam logic [2:0] REG_KEY_RED   = 3'd2;
  localparam logic [2:0] REG_KEY_GREEN = 3'd3;
  localparam logic [2:0] REG_KEY_BLUE  = 3'd4;
  localparam logic [2:0] REG_SIMILAR   = 3'd5;
  localparam logic [2:0] REG_INV_BLEND = 3'd6;

  localparam logic [17:0] DIST_DEN   = 18'd195075;
  localparam logic [31:0] DIST_RECIP = 32'((64'd1 << 48) / 64'd195075);
  localparam logic [18:0] THIRD_MUL  = 19'd349526;

  localparam logic [24:0] RECIP_D8  = 25'((64'd1 << 32) / ((64'd1 << 8) - 64'd1));
  localparam logic [24:0] RECIP_D9  = 25'((64'd1 << 32) / ((64'd1 << 9) - 64'd1));
  localparam logic [24:0] RECIP_D10 = 25'((64'd1 << 32) / ((64'd1 << 10) - 64'd1));
  localparam logic [24:0] RECIP_D11 = 25'((64'd1 << 32) / ((64'd1 << 11) - 64'd1));
  localparam logic [24:0] RECIP_D12 = 25'((64'd1 << 32) / ((64'd1 << 12) - 64'd1));
  localparam logic [24:0] RECIP_D13 = 25'((64'd1 << 32) / ((64'd1 << 13) - 64'd1));
  localparam logic [24:0] RECIP_D14 = 25'((64'd1 << 32) / ((64'd1 << 14) - 64'd1));
  localparam logic [24:0] RECIP_D15 = 25'((64'd1 << 32) / ((64'd1 << 15) - 64'd1));
  localparam logic [24:0] RECIP_D16 = 25'((64'd1 << 32) / ((64'd1 << 16) - 64'd1));

  function automatic logic [24:0] max_recip(input logic [4:0] dep);
    logic [24:0] r;
    unique case (dep)
      5'd8:    r = RECIP_D8;
      5'd9:    r = RECIP_D9;
      5'd10:   r = RECIP_D10;
      5'd11:   r = RECIP_D11;
      5'd12:   r = RECIP_D12;
      5'd13:   r = RECIP_D13;
      5'd14:   r = RECIP_D14;
      5'd15:   r = RECIP_D15;
      default: r = RECIP_D16;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/ckah_if.sv
// Stream interfaces for the color key alpha and hold block.
// One carries input pixels, the other result pixels; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ckah_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface ckah_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface
`default_nettype wire

>>> sv/color_key_alpha_and_hold.sv
// Top level of the color key alpha and hold block.
// Depends on ckah_pkg, ckah_if and ckah_isqrt.
//
// Input words arrive on pix_in and result words leave on pix_out, both
// valid/ready streams; a word moves at an edge where valid and ready are high.
// The registers are written through cfg_we_i, cfg_idx_i and cfg_data_i.
// The user must write them only while the stream is idle; it is not enforced.
// Every input word gives one result word: nine stages scale the channels and
// form the normalized squared distance, seventeen stages take the square root
// one bit each, and four stages form the weight and the hold mix.
// One word is taken every cycle. When the receiver stalls, words pile up in
// the empty stages and the input stalls only once every stage holds a word.
// Reset empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module color_key_alpha_and_hold (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [21:0] cfg_data_i,
  ckah_in_if.sink          pix_in,
  ckah_out_if.source       pix_out
);
  import ckah_pkg::*;

  logic        mode_q;
  logic [4:0]  depth_q;
  logic [7:0]  key_q [3];
  logic [16:0] sim_q;
  logic [21:0] ib_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      depth_q  <= 5'd8;
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      sim_q    <= 17'd655;
      ib_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:      mode_q   <= cfg_data_i[0];
        REG_DEPTH:     depth_q  <= cfg_data_i[4:0];
        REG_KEY_RED:   key_q[0] <= cfg_data_i[7:0];
        REG_KEY_GREEN: key_q[1] <= cfg_data_i[7:0];
        REG_KEY_BLUE:  key_q[2] <= cfg_data_i[7:0];
        REG_SIMILAR:   sim_q    <= cfg_data_i[16:0];
        REG_INV_BLEND: ib_q     <= cfg_data_i[21:0];
        default: ;
      endcase
    end
  end

  logic [4:0]  dep;
  logic [15:0] maxv;
  logic [24:0] recip;
  assign dep   = (depth_q < 5'd8) ? 5'd8 : ((depth_q > 5'd16) ? 5'd16 : depth_q);
  assign maxv  = 16'((17'd1 << dep) - 17'd1);
  assign recip = max_recip(dep);

  localparam int NF = 9;
  logic [NF-1:0] fv_q;
  logic [NF:0]   fen;
  pix_t          fpix_q [NF];
  logic          sq_ready;

  always_comb begin
    fen[NF] = sq_ready;
    for (int k = NF - 1; k >= 0; k--) begin
      fen[k] = !fv_q[k] || fen[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (fen[0]) begin
        fv_q[0] <= pix_in.valid;
      end
      for (int k = 1; k < NF; k++) begin
        if (fen[k]) begin
          fv_q[k] <= fv_q[k-1];
        end
      end
    end
  end

  pix_t in_pix;
  logic [15:0] raw_c [3];
  logic [15:0] sat_c [3];
  assign raw_c[0] = pix_in.red;
  assign raw_c[1] = pix_in.green;
  assign raw_c[2] = pix_in.blue;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_c[c] = (raw_c[c] > maxv) ? maxv : raw_c[c];
    end
    in_pix.r_raw = pix_in.red;
    in_pix.g_raw = pix_in.green;
    in_pix.b_raw = pix_in.blue;
    in_pix.a_raw = pix_in.alpha;
    in_pix.r_sat = sat_c[0];
    in_pix.g_sat = sat_c[1];
    in_pix.b_sat = sat_c[2];
  end

  always_ff @(posedge clk_i) begin
    if (fen[0]) begin
      fpix_q[0] <= in_pix;
    end
    for (int k = 1; k < NF; k++) begin
      if (fen[k]) begin
        fpix_q[k] <= fpix_q[k-1];
      end
    end
  end

  logic [31:0] num1_q [3];
  logic [31:0] num2_q [3];
  logic [16:0] quo2_q [3];
  logic [15:0] sc3_q  [3];
  logic [31:0] sq4_q  [3];
  logic [33:0] sum5_q;
  logic [33:0] sum6_q;
  logic [63:0] plo6_q;
  logic [32:0] phi6_q;
  logic [33:0] sum7_q;
  logic [32:0] est7_q;
  logic [49:0] x8_q;
  logic [32:0] est8_q;
  logic [50:0] pm8_q;
  logic [32:0] v9_q;

  logic [56:0] prod2 [3];
  logic [31:0] rem3  [3];
  logic [15:0] kk4   [3];
  logic [15:0] d4    [3];
  logic [50:0] r9;
  logic [19:0] r9s;
  logic [2:0]  cnt9;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod2[c] = 57'(num1_q[c]) * 57'(recip);
      rem3[c]  = num2_q[c] - 32'(quo2_q[c] * 32'(maxv));
      kk4[c]   = {key_q[c], 8'd0};
      d4[c]    = (sc3_q[c] >= kk4[c]) ? sc3_q[c] - kk4[c] : kk4[c] - sc3_q[c];
    end
    r9   = 51'(x8_q) - pm8_q;
    r9s  = r9[19:0];
    cnt9 = 3'(r9s >= 20'(DIST_DEN)) + 3'(r9s >= 20'(2 * DIST_DEN))
         + 3'(r9s >= 20'(3 * DIST_DEN)) + 3'(r9s >= 20'(4 * DIST_DEN));
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (fen[0]) begin
        num1_q[c] <= 32'(sat_c[c]) * 32'd65280 + 32'(maxv >> 1);
      end
      if (fen[1]) begin
        num2_q[c] <= num1_q[c];
        quo2_q[c] <= prod2[c][48:32];
      end
      if (fen[2]) begin
        sc3_q[c] <= 16'(quo2_q[c] + 17'(rem3[c] >= 32'(maxv)));
      end
      if (fen[3]) begin
        sq4_q[c] <= 32'(d4[c]) * 32'(d4[c]);
      end
    end
    if (fen[4]) begin
      sum5_q <= 34'(sq4_q[0]) + 34'(sq4_q[1]) + 34'(sq4_q[2]);
    end
    if (fen[5]) begin
      sum6_q <= sum5_q;
      plo6_q <= 64'(sum5_q[31:0]) * 64'(DIST_RECIP);
      phi6_q <= 33'(sum5_q[33:32]) * 33'(DIST_RECIP);
    end
    if (fen[6]) begin
      sum7_q <= sum6_q;
      est7_q <= phi6_q + 33'(plo6_q[63:32]);
    end
    if (fen[7]) begin
      x8_q   <= {sum7_q, 16'd0};
      est8_q <= est7_q;
      pm8_q  <= 51'(est7_q) * 51'(DIST_DEN);
    end
    if (fen[8]) begin
      v9_q <= est8_q + 33'(cnt9);
    end
  end

  logic        rt_valid;
  logic        rt_ready;
  logic [16:0] rt_root;
  pix_t        rt_pix;

  ckah_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fv_q[NF-1]),
    .in_ready_o  (sq_ready),
    .in_val_i    (v9_q),
    .in_side_i   (fpix_q[NF-1]),
    .out_valid_o (rt_valid),
    .out_ready_i (rt_ready),
    .out_root_o  (rt_root),
    .out_side_o  (rt_pix)
  );

  localparam int NB = 4;
  logic [NB-1:0] bv_q;
  logic [NB:0]   ben;
  pix_t          bpix_q [NB-1];

  always_comb begin
    ben[NB] = pix_out.ready;
    for (int k = NB - 1; k >= 0; k--) begin
      ben[k] = !bv_q[k] || ben[k+1];
    end
  end
  assign rt_ready = ben[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      if (ben[0]) begin
        bv_q[0] <= rt_valid;
      end
      for (int k = 1; k < NB; k++) begin
        if (ben[k]) begin
          bv_q[k] <= bv_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben[0]) begin
      bpix_q[0] <= rt_pix;
    end
    for (int k = 1; k < NB - 1; k++) begin
      if (ben[k]) begin
        bpix_q[k] <= bpix_q[k-1];
      end
    end
  end

  logic        gt1_q;
  logic [38:0] p1_q;
  logic [17:0] sum1_q;
  logic [15:0] w2_q;
  logic [15:0] gray2_q;
  logic [15:0] w3_q;
  logic [31:0] gw3_q;
  logic [31:0] cr3_q [3];

  logic        gt;
  logic [16:0] diff;
  logic [39:0] ramp2;
  logic [15:0] w2;
  logic [36:0] gray2;
  logic [15:0] csat2 [3];
  logic [15:0] craw3 [3];
  logic [32:0] tot4  [3];
  logic [15:0] mix4  [3];

  always_comb begin
    gt    = rt_root > sim_q;
    diff  = rt_root - sim_q;
    ramp2 = 40'(p1_q[23:0]) * 40'(maxv);
    if (ib_q == '0) begin
      w2 = gt1_q ? maxv : '0;
    end else if (!gt1_q) begin
      w2 = '0;
    end else if (p1_q[38:24] != '0) begin
      w2 = maxv;
    end else begin
      w2 = ramp2[39:24];
    end
    gray2 = 37'(sum1_q) * 37'(THIRD_MUL);
    csat2[0] = bpix_q[1].r_sat;
    csat2[1] = bpix_q[1].g_sat;
    csat2[2] = bpix_q[1].b_sat;
    craw3[0] = bpix_q[2].r_raw;
    craw3[1] = bpix_q[2].g_raw;
    craw3[2] = bpix_q[2].b_raw;
    for (int c = 0; c < 3; c++) begin
      tot4[c] = 33'(gw3_q) + 33'(cr3_q[c]) + 33'(maxv >> 1);
      mix4[c] = 16'(tot4[c] >> dep);
    end
  end

  logic [15:0] out_c_q [3];
  logic [15:0] out_a_q;

  always_ff @(posedge clk_i) begin
    if (ben[0]) begin
      gt1_q  <= gt;
      p1_q   <= gt ? 39'(diff) * 39'(ib_q) : '0;
      sum1_q <= 18'(rt_pix.r_sat) + 18'(rt_pix.g_sat) + 18'(rt_pix.b_sat);
    end
    if (ben[1]) begin
      w2_q    <= w2;
      gray2_q <= gray2[35:20];
    end
    if (ben[2]) begin
      w3_q  <= w2_q;
      gw3_q <= 32'(gray2_q) * 32'(w2_q);
      for (int c = 0; c < 3; c++) begin
        cr3_q[c] <= 32'(csat2[c]) * 32'(maxv - w2_q);
      end
    end
    if (ben[3]) begin
      if (!mode_q) begin
        out_a_q <= w3_q;
      end else begin
        out_a_q <= bpix_q[2].a_raw;
      end
      for (int c = 0; c < 3; c++) begin
        out_c_q[c] <= (mode_q && (w3_q != '0)) ? mix4[c] : craw3[c];
      end
    end
  end

  assign pix_out.valid     = bv_q[NB-1];
  assign pix_out.out_red   = out_c_q[0];
  assign pix_out.out_green = out_c_q[1];
  assign pix_out.out_blue  = out_c_q[2];
  assign pix_out.out_alpha = out_a_q;
  assign pix_in.ready      = fen[0];

endmodule
`default_nettype wire

>>> sv/ckah_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the pixel word alongside; depends on ckah_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ckah_isqrt (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [32:0]   in_val_i,
  input  wire ckah_pkg::pix_t in_side_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [16:0]        out_root_o,
  output ckah_pkg::pix_t     out_side_o
);
  import ckah_pkg::*;

  localparam int NSTEP = 17;

  logic [NSTEP-1:0] v_q;
  logic [NSTEP:0]   en;
  logic [33:0]      rem_q [NSTEP];
  logic [33:0]      res_q [NSTEP];
  pix_t             side_q [NSTEP];
  logic [33:0]      rem_in [NSTEP];
  logic [33:0]      res_in [NSTEP];

  always_comb begin
    en[NSTEP] = out_ready_i;
    for (int k = NSTEP - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    rem_in[0] = {1'b0, in_val_i};
    res_in[0] = '0;
    for (int k = 1; k < NSTEP; k++) begin
      rem_in[k] = rem_q[k-1];
      res_in[k] = res_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTEP; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam logic [33:0] BIT = 34'd1 << (2 * (NSTEP - 1 - k));
    logic [33:0] trial;
    assign trial = res_in[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        if (rem_in[k] >= trial) begin
          rem_q[k] <= rem_in[k] - trial;
          res_q[k] <= (res_in[k] >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in[k];
          res_q[k] <= res_in[k] >> 1;
        end
        side_q[k] <= (k == 0) ? in_side_i : side_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTEP-1];
  assign out_root_o  = res_q[NSTEP-1][16:0];
  assign out_side_o  = side_q[NSTEP-1];

endmodule
`default_nettype wire

>>> sv/ckah_checker.sv
// Port-level checks for the color key alpha and hold block.
// Bound to color_key_alpha_and_hold; sees only its ports.
`timescale 1ns / 1ps
`default_nettype none
module ckah_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] out_word_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result word dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_word_i))
    else $error("stalled result word changed");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while the receiver takes words");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with the output stage empty");

endmodule

bind color_key_alpha_and_hold ckah_checker u_ckah_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pix_out.valid),
  .out_ready_i (pix_out.ready),
  .out_word_i  ({pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.out_alpha})
);
`default_nettype wire
